### sv/assert_macros.svh
// assertion macros shared by the send queue modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   `ASSERT_CLK(label, clk, rst, !(cond), msg)

`endif

### sv/tmsq_pkg.sv
// shared types, codes and sequence helpers for the tcp message send queue
// no dependencies; imported by controller, datapath and top level
package tmsq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;
   localparam int DEFAULT_TAG_WIDTH   = 16;
   localparam int MAX_RESULTS         = 16;
   localparam int NRES_W              = $clog2(MAX_RESULTS + 1);
   localparam int BYTE_SHIFT          = 3;
   localparam int SEQ_W               = 32;
   localparam int ENTRY_TAG_W         = 16;
   localparam int ENTRY_COUNT_W       = 5;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_SEGMENT = 2'd1;
   localparam logic [1:0] OP_DISCARD = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]             opcode;
      logic [15:0]            msg_tag;
      logic [18:0]            length_bits;
      logic [SEQ_W-1:0]       seq;
      logic [15:0]            num_bytes;
   } req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic                     entry_valid;
      logic [ENTRY_TAG_W-1:0]   entry_tag;
      logic [SEQ_W-1:0]         entry_end_seq;
      logic                     last;
      logic [SEQ_W-1:0]         begin_seq;
      logic [SEQ_W-1:0]         end_seq;
      logic [ENTRY_COUNT_W-1:0] entry_count;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       enqueue;
      logic       walk_init;
      logic       advance;
      logic       capture;
      logic       pop;
      logic       set_begin;
      logic       emit;
      logic       emit_pending;
      logic       emit_last;
      logic [1:0] emit_code;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] opcode;
      logic       full;
      logic       list_ok;
      logic       disc_ok;
      logic       left_zero;
      logic       before_seq;
      logic       within_to;
      logic       results_full;
      logic       pend_valid;
      logic       pop_ok;
   } dp_stat_type;

   // serial number arithmetic, modulo 2^32
   function automatic logic seq_lt(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] diff;
      diff = a - b;
      return diff[SEQ_W-1];
   endfunction

   function automatic logic seq_le(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      return (a == b) || seq_lt(a, b);
   endfunction

endpackage

### sv/tcp_message_send_queue.sv
// top level of the tcp message send queue: controller plus datapath
// depends on tmsq_pkg, tmsq_ctrl and tmsq_datapath
//
// Usage:
//   Requests enter on req_payload, accepted at a rising edge with start high
//   and busy low. Opcode 0 appends a tag whose end sequence grows by
//   length_bits / 8, opcode 1 lists up to MAX_RESULTS queued entries ending in
//   [seq, seq + num_bytes], opcode 2 moves the begin point and pops
//   acknowledged entries.
//   Every result beat appears for exactly one cycle with rsp_valid high; the
//   beat that closes a request has last set. The receiver cannot stall the
//   block, so no result is ever held back.
//   An enqueue or a rejected request is answered from the decode state; a discard
//   first moves the begin point, then pops entries one by one in the pop state; a
//   listing passes over early entries in the skip state, then captures matches in
//   the match state. busy drops with the final beat, so the next request may be
//   taken in that cycle; the walk reads one entry per cycle.
//   csr_we with csr_wdata loads the start sequence, to be raised only while idle (the
//   block does not enforce this): the queue empties and begin and end both take the value.
//   Reset empties the queue with both sequence points at zero.
module tcp_message_send_queue
   import tmsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int TAG_WIDTH   = DEFAULT_TAG_WIDTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_payload,
   output logic             rsp_valid,
   output rsp_type          rsp_payload,
   input  logic             csr_we,
   input  logic [SEQ_W-1:0] csr_wdata
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   tmsq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   tmsq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_WIDTH   (TAG_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

### sv/tmsq_ctrl.sv
// control state machine of the send queue: decode, walk and pop sequencing
// depends on tmsq_pkg and assert_macros.svh
`include "assert_macros.svh"

module tmsq_ctrl
   import tmsq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SKIP,
      S_MATCH,
      S_POP
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_IDLE;
            case (stat.opcode)
               OP_ENQUEUE: begin
                  cmd.emit = 1'b1;
                  if (stat.full) begin
                     cmd.emit_code = STATUS_FULL;
                  end else begin
                     cmd.enqueue   = 1'b1;
                     cmd.emit_code = STATUS_OK;
                  end
               end
               OP_SEGMENT: begin
                  if (stat.list_ok) begin
                     cmd.walk_init = 1'b1;
                     state_in      = S_SKIP;
                  end else begin
                     cmd.emit      = 1'b1;
                     cmd.emit_code = STATUS_RANGE;
                  end
               end
               OP_DISCARD: begin
                  if (stat.disc_ok) begin
                     cmd.set_begin = 1'b1;
                     cmd.walk_init = 1'b1;
                     state_in      = S_POP;
                  end else begin
                     cmd.emit      = 1'b1;
                     cmd.emit_code = STATUS_RANGE;
                  end
               end
               default: begin
                  cmd.emit      = 1'b1;
                  cmd.emit_code = STATUS_OK;
               end
            endcase
         end
         S_SKIP: begin
            // pass over entries that end before the segment start
            if (stat.left_zero) begin
               cmd.emit      = 1'b1;
               cmd.emit_code = STATUS_OK;
               state_in      = S_IDLE;
            end else if (stat.before_seq) begin
               cmd.advance = 1'b1;
            end else begin
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            // one match is held back so its last flag is known when it leaves
            if (!stat.left_zero && !stat.results_full && stat.within_to) begin
               cmd.capture = 1'b1;
               cmd.advance = 1'b1;
               if (stat.pend_valid) begin
                  cmd.emit         = 1'b1;
                  cmd.emit_pending = 1'b1;
               end
            end else begin
               cmd.emit         = 1'b1;
               cmd.emit_pending = stat.pend_valid;
               cmd.emit_last    = 1'b1;
               cmd.emit_code    = STATUS_OK;
               state_in         = S_IDLE;
            end
         end
         S_POP: begin
            if (stat.pop_ok) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.emit      = 1'b1;
               cmd.emit_code = STATUS_OK;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != S_IDLE);
      end
   end

   assign busy = busy_ff;

   `ASSERT_NEVER(a_no_emit_idle, clock, reset, !busy_ff && cmd.emit, "beat emitted while idle")
   `ASSERT_CLK(a_final_beat_idle, clock, reset, cmd.emit && (cmd.emit_last || !cmd.emit_pending) |=> !busy_ff, "still busy after final beat")
   `ASSERT_NEVER(a_load_when_busy, clock, reset, busy_ff && cmd.load, "request loaded while busy")

endmodule

### sv/tmsq_datapath.sv
// send queue datapath: sequence points, entry memory, walk counters, result register
// depends on tmsq_pkg and assert_macros.svh
`include "assert_macros.svh"

module tmsq_datapath
   import tmsq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
   parameter int TAG_WIDTH   = DEFAULT_TAG_WIDTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  req_type          req_payload,
   input  logic             csr_we,
   input  logic [SEQ_W-1:0] csr_wdata,
   input  ctl_cmd_type      cmd,
   output dp_stat_type      stat,
   output logic             rsp_valid,
   output rsp_type          rsp_payload
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

   // control state
   logic [SEQ_W-1:0]  begin_ff, begin_in;
   logic [SEQ_W-1:0]  end_ff, end_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic [NRES_W-1:0] nres_ff, nres_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              rsp_valid_ff;

   // payload
   req_type                req_ff;
   logic [SEQ_W-1:0]       to_ff;
   logic [SEQ_W-1:0]       rd_end_ff;
   logic [TAG_WIDTH-1:0]   rd_tag_ff;
   logic [SEQ_W-1:0]       pend_end_ff;
   logic [TAG_WIDTH-1:0]   pend_tag_ff;
   logic [1:0]             status_ff;
   logic                   ent_valid_ff;
   logic [ENTRY_TAG_W-1:0] ent_tag_ff;
   logic [SEQ_W-1:0]       ent_end_ff;
   logic                   last_ff;

   logic [SEQ_W-1:0]     end_mem [QUEUE_DEPTH];
   logic [TAG_WIDTH-1:0] tag_mem [QUEUE_DEPTH];

   logic [SEQ_W-1:0] enq_end;

   assign enq_end = end_ff + SEQ_W'(req_ff.length_bits >> BYTE_SHIFT);

   always_comb begin
      begin_in      = begin_ff;
      end_in        = end_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      left_in       = left_ff;
      nres_in       = nres_ff;
      pend_valid_in = pend_valid_ff;
      if (csr_we) begin
         begin_in = csr_wdata;
         end_in   = csr_wdata;
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else begin
         if (cmd.enqueue) begin
            end_in   = enq_end;
            tail_in  = wrap_next(tail_ff);
            count_in = count_ff + 1'b1;
         end
         if (cmd.set_begin) begin
            begin_in = req_ff.seq;
         end
         if (cmd.walk_init) begin
            idx_in        = head_ff;
            left_in       = count_ff;
            nres_in       = '0;
            pend_valid_in = 1'b0;
         end
         if (cmd.advance) begin
            idx_in  = wrap_next(idx_ff);
            left_in = left_ff - 1'b1;
         end
         if (cmd.capture) begin
            nres_in       = nres_ff + 1'b1;
            pend_valid_in = 1'b1;
         end
         // the walk index follows the head while popping
         if (cmd.pop) begin
            head_in  = wrap_next(head_ff);
            count_in = count_ff - 1'b1;
            idx_in   = wrap_next(idx_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         begin_ff      <= '0;
         end_ff        <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         left_ff       <= '0;
         nres_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         begin_ff      <= begin_in;
         end_ff        <= end_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         left_ff       <= left_in;
         nres_ff       <= nres_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= cmd.emit;
      end
   end

   // entry memory, read every cycle at the next walk index
   always_ff @(posedge clock) begin
      if (cmd.enqueue) begin
         end_mem[tail_ff] <= enq_end;
         tag_mem[tail_ff] <= TAG_WIDTH'(64'(req_ff.msg_tag));
      end
      rd_end_ff <= end_mem[idx_in];
      rd_tag_ff <= tag_mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_payload;
         to_ff  <= req_payload.seq + SEQ_W'(req_payload.num_bytes);
      end
      if (cmd.capture) begin
         pend_end_ff <= rd_end_ff;
         pend_tag_ff <= rd_tag_ff;
      end
      if (cmd.emit) begin
         if (cmd.emit_pending) begin
            status_ff    <= STATUS_OK;
            ent_valid_ff <= 1'b1;
            ent_tag_ff   <= ENTRY_TAG_W'(64'(pend_tag_ff));
            ent_end_ff   <= pend_end_ff;
            last_ff      <= cmd.emit_last;
         end else begin
            status_ff    <= cmd.emit_code;
            ent_valid_ff <= 1'b0;
            ent_tag_ff   <= '0;
            ent_end_ff   <= '0;
            last_ff      <= 1'b1;
         end
      end
   end

   always_comb begin
      stat              = '0;
      stat.opcode       = req_ff.opcode;
      stat.full         = (count_ff == CNT_W'(QUEUE_DEPTH));
      stat.list_ok      = seq_le(begin_ff, req_ff.seq) && seq_le(to_ff, end_ff);
      stat.disc_ok      = seq_le(begin_ff, req_ff.seq) && seq_le(req_ff.seq, end_ff);
      stat.left_zero    = (left_ff == '0);
      stat.before_seq   = seq_lt(rd_end_ff, req_ff.seq);
      stat.within_to    = seq_le(rd_end_ff, to_ff);
      stat.results_full = (nres_ff == NRES_W'(MAX_RESULTS));
      stat.pend_valid   = pend_valid_ff;
      stat.pop_ok       = (count_ff != '0) && seq_le(rd_end_ff, req_ff.seq);
   end

   // queue state is shown live from the registers, not latched with the beat
   always_comb begin
      rsp_payload               = '0;
      rsp_payload.status        = status_ff;
      rsp_payload.entry_valid   = ent_valid_ff;
      rsp_payload.entry_tag     = ent_tag_ff;
      rsp_payload.entry_end_seq = ent_end_ff;
      rsp_payload.last          = last_ff;
      rsp_payload.begin_seq     = begin_ff;
      rsp_payload.end_seq       = end_ff;
      rsp_payload.entry_count   = ENTRY_COUNT_W'(count_ff);
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEVER(a_count_bound, clock, reset, count_ff > CNT_W'(QUEUE_DEPTH), "occupancy above depth")
   `ASSERT_NEVER(a_nres_bound, clock, reset, nres_ff > NRES_W'(MAX_RESULTS), "too many segment beats")
   `ASSERT_CLK(a_entry_status, clock, reset, rsp_valid_ff && ent_valid_ff |-> status_ff == STATUS_OK, "entry beat with error status")

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// testbench for tcp_message_send_queue: a scripted table of requests, then random
// requests, with each result beat checked against a queue model or a scripted beat
// depends on tmsq_pkg and the rtl of tcp_message_send_queue
module testbench;
   import tmsq_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int DEPTH = DEFAULT_QUEUE_DEPTH;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 2 * DEFAULT_QUEUE_DEPTH + 8;
   localparam int MAX_REPORTS = 10;
   localparam int ITEMS_PER_PHASE = 20;
   localparam int NUM_PHASES = 6;
   localparam int OWED_DEPTH = 64;
   localparam int SCRIPT_ROWS = 32;

   typedef enum logic [1:0] {FEED_OFF, FEED_SCRIPT, FEED_RANDOM} feed_mode_type;

   typedef struct {
      req_type item;
      int      reps;
      logic    typed;
      rsp_type beat;
   } script_row_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             start;
   logic             busy;
   req_type          req_payload;
   logic             rsp_valid;
   rsp_type          rsp_payload;
   logic             csr_we;
   logic [SEQ_W-1:0] csr_wdata;

   // model of the send queue
   logic [SEQ_W-1:0] una_seq = '0;
   logic [SEQ_W-1:0] buf_end = '0;
   logic [SEQ_W-1:0] end_mem [DEPTH];
   logic [15:0]      tag_mem [DEPTH];
   int               rd_slot = 0;
   int               wr_slot = 0;
   int               fill = 0;

   rsp_type          owed_beats [OWED_DEPTH];
   int               owed_rd = 0;
   int               owed_wr = 0;
   int               owed_count = 0;
   script_row_type   script [SCRIPT_ROWS];
   int               script_len = 0;
   feed_mode_type    feed = FEED_OFF;
   int               row_at = 0;
   int               rep_at = 0;
   int               idle_pct = 0;
   int               taken = 0;
   logic             offer_typed = 1'b0;
   rsp_type          offer_beat = '0;
   logic             cfg_pending = 1'b0;
   logic [SEQ_W-1:0] cfg_value = '0;
   logic [SEQ_W-1:0] restart_seqs [NUM_PHASES];
   int               errors = 0;
   int               quiet_cycles = 0;

   tcp_message_send_queue dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   always #10 clock = ~clock;

   // serial order modulo 2^32
   function automatic logic seq_precedes(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      logic [SEQ_W-1:0] diff;
      diff = a - b;
      return diff[SEQ_W-1];
   endfunction

   function automatic logic seq_upto(input logic [SEQ_W-1:0] a, input logic [SEQ_W-1:0] b);
      return (a == b) || seq_precedes(a, b);
   endfunction

   function automatic rsp_type state_beat(input logic [1:0] status, input logic valid,
                                          input logic [15:0] tag, input logic [SEQ_W-1:0] ends,
                                          input logic last);
      rsp_type b;
      b.status        = status;
      b.entry_valid   = valid;
      b.entry_tag     = tag;
      b.entry_end_seq = ends;
      b.last          = last;
      b.begin_seq     = una_seq;
      b.end_seq       = buf_end;
      b.entry_count   = ENTRY_COUNT_W'(fill);
      return b;
   endfunction

   task automatic restart_queue(input logic [SEQ_W-1:0] s);
      una_seq = s;
      buf_end = s;
      rd_slot = 0;
      wr_slot = 0;
      fill    = 0;
   endtask

   task automatic owe_beat(input rsp_type b);
      owed_beats[owed_wr] = b;
      owed_wr = (owed_wr + 1) % OWED_DEPTH;
      owed_count++;
   endtask

   task automatic take_owed(output rsp_type b);
      b = owed_beats[owed_rd];
      owed_rd = (owed_rd + 1) % OWED_DEPTH;
      owed_count--;
   endtask

   // advance the model by one accepted request and queue up the beats it owes
   task automatic model_request(input req_type r, input logic typed, input rsp_type typed_beat);
      rsp_type          beats [MAX_RESULTS];
      int               nbeats;
      logic [SEQ_W-1:0] upto;
      int               slot;
      int               remaining;
      nbeats = 0;
      case (r.opcode)
         OP_ENQUEUE: begin
            if (fill >= DEPTH) begin
               beats[0] = state_beat(STATUS_FULL, 1'b0, '0, '0, 1'b1);
               nbeats = 1;
            end else begin
               buf_end = buf_end + SEQ_W'(r.length_bits >> BYTE_SHIFT);
               end_mem[wr_slot] = buf_end;
               tag_mem[wr_slot] = r.msg_tag;
               wr_slot = (wr_slot + 1) % DEPTH;
               fill++;
               beats[0] = state_beat(STATUS_OK, 1'b0, '0, '0, 1'b1);
               nbeats = 1;
            end
         end
         OP_SEGMENT: begin
            upto = r.seq + SEQ_W'(r.num_bytes);
            if (!(seq_upto(una_seq, r.seq) && seq_upto(upto, buf_end))) begin
               beats[0] = state_beat(STATUS_RANGE, 1'b0, '0, '0, 1'b1);
               nbeats = 1;
            end else begin
               slot = rd_slot;
               remaining = fill;
               while (remaining > 0 && seq_precedes(end_mem[slot], r.seq)) begin
                  slot = (slot + 1) % DEPTH;
                  remaining--;
               end
               while (remaining > 0 && nbeats < MAX_RESULTS &&
                      seq_upto(end_mem[slot], upto)) begin
                  beats[nbeats] = state_beat(STATUS_OK, 1'b1, tag_mem[slot], end_mem[slot], 1'b0);
                  nbeats++;
                  slot = (slot + 1) % DEPTH;
                  remaining--;
               end
               if (nbeats == 0) begin
                  beats[0] = state_beat(STATUS_OK, 1'b0, '0, '0, 1'b1);
                  nbeats = 1;
               end else begin
                  beats[nbeats - 1].last = 1'b1;
               end
            end
         end
         OP_DISCARD: begin
            if (!(seq_upto(una_seq, r.seq) && seq_upto(r.seq, buf_end))) begin
               beats[0] = state_beat(STATUS_RANGE, 1'b0, '0, '0, 1'b1);
               nbeats = 1;
            end else begin
               una_seq = r.seq;
               while (fill > 0 && seq_upto(end_mem[rd_slot], r.seq)) begin
                  rd_slot = (rd_slot + 1) % DEPTH;
                  fill--;
               end
               beats[0] = state_beat(STATUS_OK, 1'b0, '0, '0, 1'b1);
               nbeats = 1;
            end
         end
         default: begin
            beats[0] = state_beat(STATUS_OK, 1'b0, '0, '0, 1'b1);
            nbeats = 1;
         end
      endcase
      if (typed) begin
         beats[0] = typed_beat;
         nbeats = 1;
      end
      for (int i = 0; i < nbeats; i++)
         owe_beat(beats[i]);
   endtask

   // mostly well-formed requests drawn from the current window, some noise
   function automatic req_type random_request();
      req_type          r;
      logic [SEQ_W-1:0] span;
      logic [SEQ_W-1:0] room;
      int               pick;
      r.opcode      = OP_ENQUEUE;
      r.msg_tag     = 16'($urandom);
      r.length_bits = 19'($urandom);
      r.seq         = $urandom;
      r.num_bytes   = 16'($urandom);
      span = buf_end - una_seq;
      pick = $urandom_range(99);
      if (pick < 40) begin
         if ($urandom_range(4) != 0)
            r.length_bits = 19'($urandom_range(1023));
      end else if (pick < 75) begin
         r.opcode = OP_SEGMENT;
         if ($urandom_range(9) != 0) begin
            r.seq = una_seq + $urandom_range(span);
            room = buf_end - r.seq;
            r.num_bytes = 16'($urandom_range(room > 32'hFFFF ? 32'hFFFF : room));
         end
      end else if (pick < 96) begin
         r.opcode = OP_DISCARD;
         if ($urandom_range(9) != 0) begin
            if (fill > 0 && $urandom_range(1) == 1)
               r.seq = end_mem[(rd_slot + $urandom_range(fill - 1)) % DEPTH];
            else
               r.seq = una_seq + $urandom_range(span);
         end
      end else begin
         r.opcode = OP_UNUSED;
      end
      return r;
   endfunction

   task automatic add_row(input logic [1:0] op, input logic [15:0] tag, input logic [18:0] len,
                          input logic [SEQ_W-1:0] seq, input logic [15:0] nbytes, input int reps,
                          input int typed, input logic [1:0] status,
                          input logic [SEQ_W-1:0] b_seq, input logic [SEQ_W-1:0] e_seq,
                          input int count);
      script_row_type row;
      row.item.opcode       = op;
      row.item.msg_tag      = tag;
      row.item.length_bits  = len;
      row.item.seq          = seq;
      row.item.num_bytes    = nbytes;
      row.reps              = reps;
      row.typed             = (typed != 0);
      row.beat              = '0;
      row.beat.status       = status;
      row.beat.last         = 1'b1;
      row.beat.begin_seq    = b_seq;
      row.beat.end_seq      = e_seq;
      row.beat.entry_count  = ENTRY_COUNT_W'(count);
      script[script_len] = row;
      script_len++;
   endtask

   task automatic wait_drained();
      while (start || busy || owed_count != 0)
         @(negedge clock);
   endtask

   always @(posedge clock) begin : drive_and_check
      rsp_type want;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_valid) begin
            quiet_cycles = 0;
            if (owed_count == 0) begin
               errors++;
               if (errors <= MAX_REPORTS)
                  $display("unexpected result beat: %p", rsp_payload);
            end else begin
               take_owed(want);
               if (rsp_payload.status !== want.status ||
                   rsp_payload.entry_valid !== want.entry_valid ||
                   rsp_payload.entry_tag !== want.entry_tag ||
                   rsp_payload.entry_end_seq !== want.entry_end_seq ||
                   rsp_payload.last !== want.last ||
                   rsp_payload.begin_seq !== want.begin_seq ||
                   rsp_payload.end_seq !== want.end_seq ||
                   rsp_payload.entry_count !== want.entry_count) begin
                  errors++;
                  if (errors <= MAX_REPORTS)
                     $display("result mismatch: expected %p, got %p", want, rsp_payload);
               end
            end
         end
         if (start && !busy) begin
            quiet_cycles = 0;
            model_request(req_payload, offer_typed, offer_beat);
            if (req_payload.opcode != OP_UNUSED)
               taken++;
         end
         if (cfg_pending && !start && !busy && owed_count == 0) begin
            csr_we <= 1'b1;
            csr_wdata <= cfg_value;
            restart_queue(cfg_value);
            cfg_pending = 1'b0;
            quiet_cycles = 0;
         end else begin
            csr_we <= 1'b0;
            // a request still on offer and not yet taken stays put
            if (!start || !busy) begin
               if (feed != FEED_OFF && !cfg_pending && $urandom_range(99) >= idle_pct) begin
                  if (feed == FEED_SCRIPT) begin
                     req_payload <= script[row_at].item;
                     offer_typed = script[row_at].typed;
                     offer_beat = script[row_at].beat;
                     rep_at++;
                     if (rep_at >= script[row_at].reps) begin
                        rep_at = 0;
                        row_at++;
                        if (row_at == script_len)
                           feed = FEED_OFF;
                     end
                  end else begin
                     req_payload <= random_request();
                     offer_typed = 1'b0;
                  end
                  start <= 1'b1;
               end else begin
                  start <= 1'b0;
               end
            end
         end
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT)
         @(negedge clock);
      $display("FAIL tcp_message_send_queue");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      restart_seqs[0] = 32'hFFFF_FFF0;
      restart_seqs[1] = 32'h7FFF_FFF8;
      restart_seqs[2] = 32'hFFFF_FFFF;
      restart_seqs[3] = $urandom;
      restart_seqs[4] = 32'h0000_0000;
      restart_seqs[5] = $urandom;

      //      op          tag       len        seq            nbytes  reps typed status
      //      begin   end     count
      add_row(OP_SEGMENT, 16'h0000, 19'd0,     32'd0,         16'd0,     1, 1, STATUS_OK,
              0, 0, 0);      // empty window on empty queue
      add_row(OP_DISCARD, 16'h0000, 19'd0,     32'd0,         16'd0,     1, 1, STATUS_OK,
              0, 0, 0);
      add_row(OP_SEGMENT, 16'h0000, 19'd0,     32'd1,         16'd0,     1, 1, STATUS_RANGE,
              0, 0, 0);
      add_row(OP_DISCARD, 16'h0000, 19'd0,     32'hFFFF_FFFF, 16'd0,     1, 1, STATUS_RANGE,
              0, 0, 0);      // just behind begin in serial order
      add_row(OP_UNUSED,  16'hFFFF, 19'h7FFFF, 32'hFFFF_FFFF, 16'hFFFF,  1, 1, STATUS_OK,
              0, 0, 0);
      add_row(OP_ENQUEUE, 16'hFFFF, 19'd8,     32'd0,         16'd0,     1, 1, STATUS_OK,
              0, 1, 1);
      add_row(OP_ENQUEUE, 16'h0000, 19'd0,     32'd0,         16'd0,     1, 1, STATUS_OK,
              0, 1, 2);      // zero length message
      add_row(OP_ENQUEUE, 16'h1234, 19'd2047,  32'd0,         16'd0,     1, 1, STATUS_OK,
              0, 256, 3);
      add_row(OP_SEGMENT, 16'h0000, 19'd0,     32'd0,         16'd1,     1, 0, STATUS_OK,
              0, 0, 0);
      add_row(OP_SEGMENT, 16'h0000, 19'd0,     32'd2,         16'd10,    1, 0, STATUS_OK,
              0, 0, 0);      // no entry ends in the window
      add_row(OP_ENQUEUE, 16'h00A5, 19'd16,    32'd0,         16'd0,    13, 0, STATUS_OK,
              0, 0, 0);
      add_row(OP_ENQUEUE, 16'h5A00, 19'd8,     32'd0,         16'd0,     1, 1, STATUS_FULL,
              0, 282, 16);
      add_row(OP_SEGMENT, 16'h0000, 19'd0,     32'd0,         16'd282,   1, 0, STATUS_OK,
              0, 0, 0);      // whole queue listed
      add_row(OP_SEGMENT, 16'h0000, 19'd0,     32'd257,       16'd26,    1, 1, STATUS_RANGE,
              0, 282, 16);
      add_row(OP_DISCARD, 16'h0000, 19'd0,     32'd256,       16'd0,     1, 0, STATUS_OK,
              0, 0, 0);
      add_row(OP_DISCARD, 16'h0000, 19'd0,     32'd255,       16'd0,     1, 1, STATUS_RANGE,
              256, 282, 13);
      add_row(OP_DISCARD, 16'h0000, 19'd0,     32'd282,       16'd0,     1, 0, STATUS_OK,
              0, 0, 0);      // pops until empty
      add_row(OP_ENQUEUE, 16'h0007, 19'h7FFFF, 32'd0,         16'd0,     1, 0, STATUS_OK,
              0, 0, 0);
      add_row(OP_SEGMENT, 16'h0000, 19'd0,     32'd282,       16'hFFFF,  1, 0, STATUS_OK,
              0, 0, 0);
      add_row(OP_DISCARD, 16'h0000, 19'd0,     32'd65817,     16'd0,     1, 0, STATUS_OK,
              0, 0, 0);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      idle_pct = 10;
      feed = FEED_SCRIPT;
      while (feed != FEED_OFF)
         @(negedge clock);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         // hold off until every owed beat is in, then restart the sequence space
         wait_drained();
         cfg_value = restart_seqs[phase];
         cfg_pending = 1'b1;
         while (cfg_pending)
            @(negedge clock);
         idle_pct = (phase < 2) ? 10 : ((phase < 4) ? 51 : 0);
         taken = 0;
         feed = FEED_RANDOM;
         while (taken < ITEMS_PER_PHASE)
            @(negedge clock);
         feed = FEED_OFF;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (owed_count != 0) begin
         errors += owed_count;
         $display("%0d result beats never arrived", owed_count);
      end
      if (errors == 0)
         $display("PASS tcp_message_send_queue");
      else
         $display("FAIL tcp_message_send_queue");
      $finish;
   end

endmodule

### filelist.f
+incdir+sv
sv/tmsq_pkg.sv
sv/tmsq_ctrl.sv
sv/tmsq_datapath.sv
sv/tcp_message_send_queue.sv
dv/testbench.sv
